>>> sv/fmsb_pkg.sv
// shared constants, types and helper functions for the frame mirror block
package fmsb_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W  = WD_W + HD_W;
    localparam int DIM_W  = (WD_W > HD_W) ? WD_W : HD_W;
    localparam int COORD_W = DIM_W + 2;

    localparam int PIX_W      = 16;
    localparam int SIZE_W     = 9;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_DATA_W  = 24;
    localparam int MIRROR_BIT = PIX_W;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(240);
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(240);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = CFG_IDX_W'(3);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic capture;
        logic calc;
        logic read;
    } t_cmd;

    function automatic logic [WD_W-1:0] clamp_width(input logic [SIZE_W-1:0] v);
        logic [WD_W-1:0] r;
        if (v == '0) begin
            r = WD_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WD_W'(MAX_WIDTH);
        end else begin
            r = WD_W'(v);
        end
        return r;
    endfunction

    function automatic logic [HD_W-1:0] clamp_height(input logic [SIZE_W-1:0] v);
        logic [HD_W-1:0] r;
        if (v == '0) begin
            r = HD_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HD_W'(MAX_HEIGHT);
        end else begin
            r = HD_W'(v);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] byte_swap(input logic [PIX_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

>>> sv/fmsb_ctrl.sv
// controller state machine sequencing load and emit words
module fmsb_ctrl
    import fmsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_action,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_action == ACT_EMIT)) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_READ;
            S_READ: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid && (i_action == ACT_LOAD);
                o_cmd.capture = i_in_valid && (i_action == ACT_EMIT);
            end
            S_CALC:  o_cmd.calc  = 1'b1;
            S_READ:  o_cmd.read  = 1'b1;
            S_OUT:   o_out_valid = 1'b1;
            default: o_in_ready  = 1'b0;
        endcase
    end

endmodule

>>> sv/fmsb_datapath.sv
// config registers, counters, address mapping and frame store
module fmsb_datapath
    import fmsb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_mirror,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_end
);

    logic [PIX_W-1:0] r_store [STORE_DEPTH];

    logic [SIZE_W-1:0]         r_frame_width;
    logic [SIZE_W-1:0]         r_frame_height;
    logic signed [SHIFT_W-1:0] r_shift_x;
    logic signed [SHIFT_W-1:0] r_shift_y;

    logic [ADDR_W-1:0] r_load_pos;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_mirror;
    logic [ADDR_W-1:0] r_addr;
    logic              r_in_range;
    logic              r_frame_end;
    logic [PIX_W-1:0]  r_rd_data;

    logic [WD_W-1:0]           w;
    logic [HD_W-1:0]           h;
    logic [TOT_W-1:0]          total;
    logic                      load_wrap;
    logic signed [COORD_W-1:0] x_s;
    logic signed [COORD_W-1:0] y_s;
    logic signed [COORD_W-1:0] w_s;
    logic signed [COORD_W-1:0] h_s;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic                      in_range;
    logic [ADDR_W-1:0]         addr;
    logic                      col_wrap;
    logic                      row_wrap;

    always_comb begin
        w         = clamp_width(r_frame_width);
        h         = clamp_height(r_frame_height);
        total     = TOT_W'(w) * TOT_W'(h);
        load_wrap = (TOT_W'(r_load_pos) + TOT_W'(1)) >= total;

        x_s = $signed(COORD_W'(r_out_col));
        y_s = $signed(COORD_W'(r_out_row));
        w_s = $signed(COORD_W'(w));
        h_s = $signed(COORD_W'(h));
        sx  = r_mirror ? (w_s - COORD_W'(1) - x_s) : x_s;
        sx  = sx - COORD_W'(r_shift_x);
        sy  = y_s - COORD_W'(r_shift_y);

        in_range = (sx >= 0) && (sx < w_s) && (sy >= 0) && (sy < h_s);
        addr     = ADDR_W'(ADDR_W'(sy[ROW_W-1:0]) * ADDR_W'(w)
                           + ADDR_W'(sx[COL_W-1:0]));

        col_wrap = (WD_W'(r_out_col) + WD_W'(1)) >= w;
        row_wrap = (HD_W'(r_out_row) + HD_W'(1)) >= h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_shift_x      <= '0;
            r_shift_y      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_SHIFT_X:      r_shift_x      <= i_cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y:      r_shift_y      <= i_cfg_data[SHIFT_W-1:0];
                default:          r_shift_y      <= r_shift_y;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_load_pos <= load_wrap ? '0 : r_load_pos + 1'b1;
            end
            if (i_cmd.calc) begin
                if (col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= row_wrap ? '0 : r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mirror <= i_mirror;
        end
        if (i_cmd.calc) begin
            r_addr      <= addr;
            r_in_range  <= in_range;
            r_frame_end <= col_wrap && row_wrap;
        end
    end

    // frame store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_store[r_load_pos] <= i_pixel_in;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_store[r_addr];
        end
    end

    assign o_pixel_out = r_in_range ? byte_swap(r_rd_data) : '0;
    assign o_frame_end = r_frame_end;

endmodule

>>> sv/frame_mirror_shift_byteswap.sv
// Frame mirror/shift/byte-swap top level. A load word (tuser = 0) writes one
// 16-bit pixel into the frame store in raster order. An emit word (tuser = 1)
// maps the next output pixel to a source position (optional horizontal
// mirror, then the gaze offsets), reads the store and presents the
// byte-swapped pixel, or zero outside the frame, with tlast on the last pixel
// of the frame. After an emit word is accepted, the address is computed and
// registered, then the store read is registered, then the result is
// presented and held while the output is stalled. The next word is accepted
// once the result has been taken. The frame store is single-port and the
// controller handles one word at a time. No new word is taken while a result
// waits. Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the store has no clearing pass, so every pixel must be loaded before it is
// emitted.
module frame_mirror_shift_byteswap
    import fmsb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // pixel_in, mirror, zero pad
    input  logic                  i_s_axis_tuser,  // action
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [PIX_W-1:0]      o_m_axis_tdata,  // pixel_out
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;

    fmsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_action    (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    fmsb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pixel_in  (i_s_axis_tdata[PIX_W-1:0]),
        .i_mirror    (i_s_axis_tdata[MIRROR_BIT]),
        .o_pixel_out (o_m_axis_tdata),
        .o_frame_end (o_m_axis_tlast)
    );

endmodule

>>> sv/fmsb_checker.sv
// port-level checker for the frame mirror block and its bind
module fmsb_assertions
    import fmsb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             i_s_axis_tready,
    input logic             i_s_axis_tuser,
    input logic             i_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [PIX_W-1:0] i_m_axis_tdata,
    input logic             i_m_axis_tlast
);

    logic in_acc;

    assign in_acc = i_s_axis_tvalid && i_s_axis_tready;

    a_no_accept_while_pending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> !i_s_axis_tready
    ) else $error("input word accepted while result pending");

    a_emit_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_axis_tuser == ACT_EMIT)) |-> ##3 i_m_axis_tvalid
    ) else $error("emit word did not produce a result");

    a_load_gives_none: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_axis_tuser == ACT_LOAD)) |=> !i_m_axis_tvalid
    ) else $error("load word produced a result");

    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast))
    ) else $error("stalled result changed");

endmodule

bind frame_mirror_shift_byteswap fmsb_assertions u_fmsb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

>>> sim/fmsb_checker.sv
// checker for the frame mirror block: tracks the frame store and counters, compares each pixel
`timescale 1ns / 1ps
module fmsb_checker
    import fmsb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pixel_in, mirror, zero pad
    input  logic                  i_s_tuser,   // action
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [PIX_W-1:0]      i_m_tdata,   // pixel_out
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_out_pixel;

    logic [PIX_W-1:0]   frame_store [STORE_DEPTH];
    logic [ADDR_W-1:0]  wr_pos;
    logic [COL_W-1:0]   out_col;
    logic [ROW_W-1:0]   out_row;
    logic [SIZE_W-1:0]  reg_width;
    logic [SIZE_W-1:0]  reg_height;
    logic [SHIFT_W-1:0] reg_shift_x;
    logic [SHIFT_W-1:0] reg_shift_y;
    t_out_pixel         pixel_q [$];
    int                 fails = 0;

    function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int maxv);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    task automatic take_word(input logic act, input logic [IN_DATA_W-1:0] data);
        int         w;
        int         h;
        int         total;
        int         sx;
        int         sy;
        logic       col_wrap;
        logic       row_wrap;
        logic [PIX_W-1:0] v;
        t_out_pixel e;
        w     = clamp_dim(reg_width, MAX_WIDTH);
        h     = clamp_dim(reg_height, MAX_HEIGHT);
        total = w * h;
        if (act == ACT_LOAD) begin
            frame_store[wr_pos] = data[PIX_W-1:0];
            wr_pos = (int'(wr_pos) + 1 >= total) ? '0 : wr_pos + 1'b1;
        end else begin
            sx = data[MIRROR_BIT] ? (w - 1 - int'(out_col)) : int'(out_col);
            sx = sx - int'($signed(reg_shift_x));
            sy = int'(out_row) - int'($signed(reg_shift_y));
            v  = '0;
            if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
                v = frame_store[sy * w + sx];
            end
            col_wrap = (int'(out_col) + 1 >= w);
            row_wrap = (int'(out_row) + 1 >= h);
            e.pixel  = {v[7:0], v[15:8]};
            e.last   = col_wrap && row_wrap;
            pixel_q.push_back(e);
            if (col_wrap) begin
                out_col = '0;
                out_row = row_wrap ? '0 : out_row + 1'b1;
            end else begin
                out_col = out_col + 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_pixel e;
        if (!i_rst_n) begin
            wr_pos      = '0;
            out_col     = '0;
            out_row     = '0;
            reg_width   = RST_FRAME_WIDTH;
            reg_height  = RST_FRAME_HEIGHT;
            reg_shift_x = '0;
            reg_shift_y = '0;
            pixel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  reg_width   = i_cfg_data[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: reg_height  = i_cfg_data[SIZE_W-1:0];
                    REG_SHIFT_X:      reg_shift_x = i_cfg_data[SHIFT_W-1:0];
                    REG_SHIFT_Y:      reg_shift_y = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                take_word(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pixel_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected word: pixel %h last %b", i_m_tdata, i_m_tlast);
                    end
                end else begin
                    e = pixel_q.pop_front();
                    if (i_m_tdata !== e.pixel || i_m_tlast !== e.last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                                     e.pixel, e.last, i_m_tdata, i_m_tlast);
                        end
                    end
                end
            end
        end
        o_pending    <= pixel_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/tb.sv
// testbench top for the frame mirror block: stimulus, flow control, watchdog and verdict
`timescale 1ns / 1ps
module tb;
    import fmsb_pkg::*;

    localparam int TOTAL_ITEMS  = 1974;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [PIX_W-1:0]      o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    int load_pos     = 0;
    int fill_mark    = 0;
    int frame_total  = 240 * 240;
    int sent         = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    bit calm         = 1'b0;
    bit hold_req     = 1'b0;

    frame_mirror_shift_byteswap DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    fmsb_checker CHK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tlast    (o_m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: random stalls, one long hold on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(99) < sink_idle_pct) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(16, 1)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic act, input logic [PIX_W-1:0] pix, input logic mir);
        if (!calm && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'({mir, pix});
        i_s_axis_tuser  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (act == ACT_LOAD) begin
            if (load_pos == fill_mark) begin
                fill_mark++;
            end
            load_pos = (load_pos + 1 >= frame_total) ? 0 : load_pos + 1;
        end
        sent++;
        if (sent >= TOTAL_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
        end
    endtask

    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int raw_w, input int raw_h, input int shx, input int shy);
        int eff_w;
        int eff_h;
        wait_quiet();
        cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(raw_w));
        cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(raw_h));
        cfg_write(REG_SHIFT_X, {(CFG_DATA_W-SHIFT_W)'($urandom), SHIFT_W'(shx)});
        cfg_write(REG_SHIFT_Y, {(CFG_DATA_W-SHIFT_W)'($urandom), SHIFT_W'(shy)});
        i_cfg_we <= 1'b0;
        eff_w = (raw_w == 0) ? 1 : ((raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w);
        eff_h = (raw_h == 0) ? 1 : ((raw_h > MAX_HEIGHT) ? MAX_HEIGHT : raw_h);
        frame_total = eff_w * eff_h;
    endtask

    // every position an emit can read must hold a loaded pixel
    task automatic fill_frame();
        while (fill_mark < frame_total) begin
            send_word(ACT_LOAD, PIX_W'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        logic [PIX_W-1:0] corner_pix [12];
        int phase;
        int n;
        int i;
        int shx;
        int shy;
        int emit_pct;
        corner_pix = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8001, 16'h7FFE,
                       16'hA55A, 16'h5AA5, 16'h0001, 16'h8000, 16'h1234, 16'hFEDC};
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_LOAD;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small frame, extreme pixels, plain then mirrored emits
        set_frame(4, 3, 0, 0);
        for (i = 0; i < 12; i++) begin
            send_word(ACT_LOAD, corner_pix[i], i[0]);
        end
        for (i = 0; i < 12; i++) begin
            send_word(ACT_EMIT, ~corner_pix[i], i >= 6);
        end

        phase = 0;
        while (sent < TOTAL_ITEMS) begin
            shx = int'($urandom_range(31)) - 16;
            shy = int'($urandom_range(31)) - 16;
            case (phase)
                0: set_frame(256, 1, -16, 0);
                1: set_frame(1, 256, 15, -16);
                2: set_frame(0, 0, 15, 15);
                3: set_frame(511, 1, -12, 12);
                4: set_frame(1, 300, 0, -5);
                default: begin
                    if ($urandom_range(7) == 0) begin
                        set_frame($urandom_range(511), 1, shx, shy);
                    end else begin
                        set_frame($urandom_range(24, 1), $urandom_range(24, 1), shx, shy);
                    end
                end
            endcase
            fill_frame();
            src_idle_pct  = 15 * $urandom_range(2);
            sink_idle_pct = 15 * $urandom_range(2);
            emit_pct      = 30 + 20 * $urandom_range(2);
            if (phase == 6) begin
                hold_req = 1'b1;
            end
            n = $urandom_range(160, 60);
            for (i = 0; i < n && sent < TOTAL_ITEMS; i++) begin
                send_word(($urandom_range(99) < emit_pct) ? ACT_EMIT : ACT_LOAD,
                          PIX_W'($urandom), 1'($urandom));
            end
            phase++;
        end

        wait_quiet();
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
